>>> rtl/cfm_pkg.sv
// Shared types, constants and tables for the corner fan segment mask block.
// No dependencies; imported by every module and interface of the block.
package cfm_pkg;

  localparam int MAX_DIM         = 4096;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ACC_BITS        = 30;
  localparam int CORDIC_ITERS    = ANGLE_FRAC_BITS + 2;

  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int DIFF_W = DIM_W + 1;
  localparam int MASK_W = 8;

  // CORDIC datapath: 13-bit magnitude scaled by 2^16, times gain and sqrt(2)
  localparam int PRESCALE_SH = 16;
  localparam int XY_W        = 32;
  localparam int Z_W         = 33;

  // 0.999 in Q20, rounded half up to ANGLE_FRAC_BITS fraction bits
  localparam int SCALE_Q20 = 1047527;
  localparam int SCALE_W   = 21;
  localparam int PROD_W    = Z_W + SCALE_W + 1;
  localparam int ROUND_SH  = 20 + ACC_BITS - ANGLE_FRAC_BITS;
  localparam int ANG_W     = PROD_W - ROUND_SH;
  localparam int SEG_W     = 5;
  localparam int IDX_W     = 4;
  localparam int NUM_IDX   = 12;

  localparam logic signed [Z_W-1:0] Z_ONE = Z_W'(64'sd1 <<< ACC_BITS);
  localparam logic signed [Z_W-1:0] Z_TWO = Z_W'(64'sd2 <<< ACC_BITS);

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWELVE_SEGMENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd3;

  // Corner codes 0..3 = TL, TR, BR, BL; bit c set when that corner sits at W / H
  localparam logic [3:0] CORNER_RIGHT_MASK  = 4'b0110;
  localparam logic [3:0] CORNER_BOTTOM_MASK = 4'b1100;

  // Fan level per segment index (twelve-segment spacing; six uses even entries)
  localparam logic [MASK_W-1:0] MASK_LUT [NUM_IDX] = '{
    8'd0, 8'd21, 8'd42, 8'd64, 8'd85, 8'd106,
    8'd128, 8'd149, 8'd170, 8'd192, 8'd213, 8'd234
  };

  localparam longint ATAN_LOW [11] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544
  };
  localparam longint INV_PI_2P31 = 683565276;

  typedef struct packed {
    logic [1:0]       corner;
    logic             twelve;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic                    special;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cord_t;

  // atan(2^-i) * 2^31 / pi, rounded
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    longint v;
    if (i < 11) v = ATAN_LOW[i];
    else        v = (INV_PI_2P31 + (64'sd1 <<< (i - 1))) >>> i;
    return Z_W'(v);
  endfunction

endpackage

>>> rtl/cfm_pix_if.sv
// Pixel coordinate channel: valid/ready handshake with a 12-bit x/y payload.
// Depends on cfm_pkg.
interface cfm_pix_if import cfm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> rtl/cfm_mask_if.sv
// Mask result channel: valid/ready handshake with an 8-bit mask byte.
// Depends on cfm_pkg.
interface cfm_mask_if import cfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] mask_value;

  modport source (output valid, output mask_value, input ready);
  modport sink   (input valid, input mask_value, output ready);
endinterface

>>> rtl/cfm_front.sv
// Front stage: corner-relative vector, axis cases, half-plane fold for CORDIC.
// Depends on cfm_pkg and cfm_pix_if.
module cfm_front import cfm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  cfm_pix_if.sink      pix,
  output logic         out_valid,
  input  logic         out_ready,
  output cord_t        out_data
);

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIM_W-1:0]         cx, cy;
  logic                     special;
  cord_t                    cord;
  logic                     valid_r;
  cord_t                    data_r;
  logic                     load;

  always_comb begin
    cx = CORNER_RIGHT_MASK[cfg.corner]  ? cfg.width  : '0;
    cy = CORNER_BOTTOM_MASK[cfg.corner] ? cfg.height : '0;
    dx = signed'(DIFF_W'(pix.pixel_x)) - signed'(DIFF_W'(cx));
    dy = signed'(DIFF_W'(pix.pixel_y)) - signed'(DIFF_W'(cy));
    special = (dx == '0) || (dy == '0);

    cord.special = special;
    cord.x = XY_W'(dx) <<< PRESCALE_SH;
    cord.y = XY_W'(dy) <<< PRESCALE_SH;
    cord.z = '0;
    if (special) begin
      cord.x = '0;
      cord.y = '0;
      if (dy == '0) cord.z = (dx < 0) ? Z_TWO : '0;
      else          cord.z = (dy > 0) ? Z_ONE : -Z_ONE;
    end else if (dx < 0) begin
      // fold into the right half plane, start a half turn away
      cord.x = -cord.x;
      cord.y = -cord.y;
      cord.z = (dy > 0) ? Z_TWO : -Z_TWO;
    end
  end

  assign pix.ready = !valid_r || out_ready;
  assign load      = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pix.ready) begin
      valid_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= cord;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_front_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !special) |=> (data_r.x > 0))
    else $error("folded vector not in right half plane");

endmodule

>>> rtl/cfm_cordic.sv
// Vectoring CORDIC, one register stage per iteration, per-stage valid/ready.
// Depends on cfm_pkg.
module cfm_cordic import cfm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  cord_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cord_t out_data
);

  logic  valid_r [CORDIC_ITERS];
  cord_t data_r  [CORDIC_ITERS];
  logic  rdy     [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic  prev_valid;
    cord_t prev;
    cord_t data_nxt;
    logic  down_ready;

    if (i == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev       = in_data;
    end else begin : g_rest
      assign prev_valid = valid_r[i-1];
      assign prev       = data_r[i-1];
    end

    if (i == CORDIC_ITERS - 1) begin : g_last
      assign down_ready = out_ready;
    end else begin : g_mid
      assign down_ready = rdy[i+1];
    end

    assign rdy[i] = !valid_r[i] || down_ready;

    always_comb begin
      data_nxt = prev;
      if (!prev.special) begin
        if (prev.y > 0) begin
          data_nxt.x = prev.x + (prev.y >>> i);
          data_nxt.y = prev.y - (prev.x >>> i);
          data_nxt.z = prev.z + atan_step(i);
        end else begin
          data_nxt.x = prev.x - (prev.y >>> i);
          data_nxt.y = prev.y + (prev.x >>> i);
          data_nxt.z = prev.z - atan_step(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_r[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && prev_valid) begin
        data_r[i] <= data_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[CORDIC_ITERS-1];
  assign out_data  = data_r[CORDIC_ITERS-1];

  localparam logic signed [Z_W-1:0] Z_LIM = Z_TWO + Z_W'(64'sd1 <<< 24);

  a_cordic_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.special) |-> (out_data.x > 0))
    else $error("CORDIC x left the right half plane");

  a_cordic_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.z <= Z_LIM && out_data.z >= -Z_LIM))
    else $error("CORDIC angle out of range");

endmodule

>>> rtl/cfm_quant.sv
// Scale by 0.999, reduce modulo a quarter turn, quantize to fan segments.
// Depends on cfm_pkg and cfm_mask_if.
module cfm_quant import cfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             twelve,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic signed [Z_W-1:0] in_z,
  cfm_mask_if.source       mask
);

  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(64'sd1 <<< (ROUND_SH - 1));
  localparam logic signed [SCALE_W:0]  SCALE_C   = (SCALE_W + 1)'(SCALE_Q20);

  logic                        prod_valid_r, mask_valid_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [MASK_W-1:0]           mask_r;
  logic                        rdy_prod, rdy_mask;

  logic signed [PROD_W-1:0]            rounded;
  logic signed [ANG_W-1:0]             ang;
  logic [ANGLE_FRAC_BITS-1:0]          low;
  logic signed [ANGLE_FRAC_BITS:0]     a;
  logic signed [ANGLE_FRAC_BITS+4:0]   a12;
  logic signed [SEG_W-1:0]             s12, s6;
  logic [IDX_W-1:0]                    idx;

  assign rdy_mask = !mask_valid_r || mask.ready;
  assign rdy_prod = !prod_valid_r || rdy_mask;
  assign in_ready = rdy_prod;

  always_comb begin
    rounded = prod_r + ROUND_ADD;
    ang     = rounded[ROUND_SH +: ANG_W];
    low     = ang[ANGLE_FRAC_BITS-1:0];
    // remainder keeps the sign of the angle
    if (ang[ANG_W-1] && (low != '0)) a = signed'({1'b1, low});
    else                             a = signed'({1'b0, low});
    a12 = ((ANGLE_FRAC_BITS + 5)'(a) <<< 3) + ((ANGLE_FRAC_BITS + 5)'(a) <<< 2);
    s12 = a12[ANGLE_FRAC_BITS +: SEG_W];
    s6  = s12 >>> 1;
    if (twelve) begin
      idx = (s12 < 0) ? IDX_W'(s12 + SEG_W'(12)) : IDX_W'(s12);
    end else begin
      idx = (s6 < 0) ? IDX_W'(s6 + SEG_W'(6)) : IDX_W'(s6);
      idx = idx << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      mask_valid_r <= 1'b0;
    end else begin
      if (rdy_prod) prod_valid_r <= in_valid;
      if (rdy_mask) mask_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_prod && in_valid) begin
      prod_r <= PROD_W'(in_z) * PROD_W'(SCALE_C);
    end
    if (rdy_mask && prod_valid_r) begin
      mask_r <= (idx < IDX_W'(NUM_IDX)) ? MASK_LUT[idx] : '0;
    end
  end

  assign mask.valid      = mask_valid_r;
  assign mask.mask_value = mask_r;

  a_quant_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_mask && prod_valid_r) |-> (idx < IDX_W'(NUM_IDX)))
    else $error("segment index out of range");

  a_quant_even: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_mask && prod_valid_r && !twelve) |-> (idx[0] == 1'b0))
    else $error("six-segment index must be even");

endmodule

>>> rtl/corner_fan_segment_mask_top.sv
// Corner fan segment mask: per-pixel wipe-mask level from the pixel's angle
// about a chosen frame corner.
//
// Channels: in_pix carries one pixel coordinate (pixel_x, pixel_y) per
// transaction; out_mask carries one mask_value byte per transaction, in order.
// Both use valid/ready; a transaction happens when both are high at clk.
// Configuration: cfg_we writes cfg_data into register cfg_index at clk
// (0 corner_select, 1 twelve_segments, 2 frame_width, 3 frame_height).
// Write only while the pipeline is empty.
//
// The pipe holds one front stage, 18 CORDIC iteration stages and two stages
// for scaling and quantization. Throughput is one pixel per cycle while
// out_mask.ready stays high. Each stage has its own valid bit and takes a
// new item when it is empty or its successor moves, so a stalled receiver
// backs the pipe up stage by stage and in_pix.ready falls only once every
// stage is full. Reset (rst_n low, synchronous) empties the pipe and sets
// corner 0, six segments and a 4096 x 4096 frame.
// Depends on cfm_pkg, cfm_pix_if, cfm_mask_if, cfm_front, cfm_cordic, cfm_quant.
module corner_fan_segment_mask_top import cfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cfm_pix_if.sink               in_pix,
  cfm_mask_if.source            out_mask,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  front_valid, front_ready;
  cord_t front_data;
  logic  cord_valid, cord_ready;
  cord_t cord_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.corner <= '0;
      cfg_r.twelve <= 1'b0;
      cfg_r.width  <= DIM_W'(MAX_DIM);
      cfg_r.height <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORNER_SELECT:   cfg_r.corner <= cfg_data[1:0];
        CFG_TWELVE_SEGMENTS: cfg_r.twelve <= cfg_data[0];
        CFG_FRAME_WIDTH:     cfg_r.width  <= cfg_data;
        CFG_FRAME_HEIGHT:    cfg_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

  cfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pix       (in_pix),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  cfm_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (cord_valid),
    .out_ready (cord_ready),
    .out_data  (cord_data)
  );

  cfm_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .twelve   (cfg_r.twelve),
    .in_valid (cord_valid),
    .in_ready (cord_ready),
    .in_z     (cord_data.z),
    .mask     (out_mask)
  );

endmodule
